// File: src/cursor_edit_buffer_assert.svh
// Assertion helpers for the cursor edit buffer checker
`ifndef CURSOR_EDIT_BUFFER_ASSERT_SVH
`define CURSOR_EDIT_BUFFER_ASSERT_SVH

// Same-cycle implication, muted while reset is low
`define CEB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, muted while reset is low
`define CEB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/ceb_pkg.sv
`default_nettype none

package ceb_pkg;

	localparam logic [2:0] KIND_LEFT   = 3'd0;
	localparam logic [2:0] KIND_RIGHT  = 3'd1;
	localparam logic [2:0] KIND_BACK   = 3'd2;
	localparam logic [2:0] KIND_INSERT = 3'd3;
	localparam logic [2:0] KIND_DUMP   = 3'd4;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_EDGE  = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] character;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] text_byte;
		logic       last;
		logic [6:0] cursor_pos;
		logic [6:0] text_length;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_PUSH,
		OP_POP
	} stack_op_t;

	typedef struct packed {
		stack_op_t left_op;
		stack_op_t right_op;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GATHER,
		ST_EMIT,
		ST_RESTORE
	} state_t;

endpackage

`default_nettype wire

// File: src/cursor_edit_buffer.sv
// An edit's transaction is registered and shown in the cycle after acceptance.
// Throughput: one edit per cycle while idle with a free output; the chain
// shifts every slot at once. A dump (N characters, L left of the cursor)
// moves L right, emits N back (one transaction each), then restores N-L.
// Reset clears the counts and the controller; character slots are not reset.
`default_nettype none

module cursor_edit_buffer #(
	parameter int CAPACITY = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire ceb_pkg::cmd_t cmd,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output ceb_pkg::rsp_t      rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	ceb_pkg::state_t     state_q, state_d;
	logic [CW-1:0]       left_cnt_q, left_cnt_d;
	logic [CW-1:0]       right_cnt_q, right_cnt_d;
	logic [CW-1:0]       orig_left_q, orig_left_d;
	logic [CW-1:0]       total;
	logic                rsp_valid_q;
	ceb_pkg::rsp_t       rsp_q, rsp_d;
	logic                load;
	logic                out_free;
	logic                accept;
	ceb_pkg::cell_ctrl_t ctrl;
	logic [7:0]          left_push;
	logic [7:0]          right_push;
	logic [7:0]          left_val  [CAPACITY];
	logic [7:0]          right_val [CAPACITY];

	// Cell chain: slot 0 is the top of each stack
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [7:0] left_above, left_below, right_above, right_below;

		if (i == 0) begin : g_head
			assign left_above  = left_push;
			assign right_above = right_push;
		end else begin : g_body
			assign left_above  = left_val[i-1];
			assign right_above = right_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign left_below  = '0;
			assign right_below = '0;
		end else begin : g_link
			assign left_below  = left_val[i+1];
			assign right_below = right_val[i+1];
		end

		ceb_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.left_above  (left_above),
			.left_below  (left_below),
			.right_above (right_above),
			.right_below (right_below),
			.left_val    (left_val[i]),
			.right_val   (right_val[i])
		);
	end

	assign total     = CW'(left_cnt_q + right_cnt_q);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = !((state_q == ceb_pkg::ST_IDLE) && out_free);
	assign accept    = cmd_valid && !cmd_stall;

	always_comb begin
		state_d        = state_q;
		left_cnt_d     = left_cnt_q;
		right_cnt_d    = right_cnt_q;
		orig_left_d    = orig_left_q;
		ctrl.left_op   = ceb_pkg::OP_HOLD;
		ctrl.right_op  = ceb_pkg::OP_HOLD;
		left_push      = '0;
		right_push     = '0;
		load           = 1'b0;
		rsp_d          = '0;

		unique case (state_q)
			ceb_pkg::ST_IDLE: begin
				if (accept) begin
					load         = 1'b1;
					rsp_d.last   = 1'b1;
					rsp_d.status = ceb_pkg::STAT_DONE;
					unique case (cmd.kind)
						ceb_pkg::KIND_LEFT: begin
							if (left_cnt_q == '0) begin
								rsp_d.status = ceb_pkg::STAT_EDGE;
							end else begin
								ctrl.left_op  = ceb_pkg::OP_POP;
								ctrl.right_op = ceb_pkg::OP_PUSH;
								right_push    = left_val[0];
								left_cnt_d    = left_cnt_q - CW'(1);
								right_cnt_d   = right_cnt_q + CW'(1);
							end
						end
						ceb_pkg::KIND_RIGHT: begin
							if (right_cnt_q == '0) begin
								rsp_d.status = ceb_pkg::STAT_EDGE;
							end else begin
								ctrl.right_op = ceb_pkg::OP_POP;
								ctrl.left_op  = ceb_pkg::OP_PUSH;
								left_push     = right_val[0];
								left_cnt_d    = left_cnt_q + CW'(1);
								right_cnt_d   = right_cnt_q - CW'(1);
							end
						end
						ceb_pkg::KIND_BACK: begin
							if (left_cnt_q == '0) begin
								rsp_d.status = ceb_pkg::STAT_EDGE;
							end else begin
								ctrl.left_op = ceb_pkg::OP_POP;
								left_cnt_d   = left_cnt_q - CW'(1);
							end
						end
						ceb_pkg::KIND_INSERT: begin
							if (total >= CW'(CAPACITY)) begin
								rsp_d.status = ceb_pkg::STAT_FULL;
							end else begin
								ctrl.left_op = ceb_pkg::OP_PUSH;
								left_push    = cmd.character;
								left_cnt_d   = left_cnt_q + CW'(1);
							end
						end
						ceb_pkg::KIND_DUMP: begin
							if (total == '0) begin
								rsp_d.status = ceb_pkg::STAT_EMPTY;
							end else begin
								// Gather everything onto the right stack, then emit
								load        = 1'b0;
								orig_left_d = left_cnt_q;
								state_d     = (left_cnt_q == '0) ? ceb_pkg::ST_EMIT
								                                 : ceb_pkg::ST_GATHER;
							end
						end
						default: rsp_d.status = ceb_pkg::STAT_EDGE;
					endcase
					rsp_d.cursor_pos  = 7'(left_cnt_d);
					rsp_d.text_length = 7'(CW'(left_cnt_d + right_cnt_d));
				end
			end

			ceb_pkg::ST_GATHER: begin
				ctrl.left_op  = ceb_pkg::OP_POP;
				ctrl.right_op = ceb_pkg::OP_PUSH;
				right_push    = left_val[0];
				left_cnt_d    = left_cnt_q - CW'(1);
				right_cnt_d   = right_cnt_q + CW'(1);
				if (left_cnt_q == CW'(1)) begin
					state_d = ceb_pkg::ST_EMIT;
				end
			end

			ceb_pkg::ST_EMIT: begin
				// Emit the right top and drop it back onto the left stack
				if (out_free) begin
					ctrl.right_op     = ceb_pkg::OP_POP;
					ctrl.left_op      = ceb_pkg::OP_PUSH;
					left_push         = right_val[0];
					left_cnt_d        = left_cnt_q + CW'(1);
					right_cnt_d       = right_cnt_q - CW'(1);
					load              = 1'b1;
					rsp_d.status      = ceb_pkg::STAT_DONE;
					rsp_d.text_byte   = right_val[0];
					rsp_d.last        = (right_cnt_q == CW'(1));
					rsp_d.cursor_pos  = 7'(orig_left_q);
					rsp_d.text_length = 7'(total);
					if (right_cnt_q == CW'(1)) begin
						state_d = (orig_left_q == total) ? ceb_pkg::ST_IDLE
						                                 : ceb_pkg::ST_RESTORE;
					end
				end
			end

			ceb_pkg::ST_RESTORE: begin
				ctrl.left_op  = ceb_pkg::OP_POP;
				ctrl.right_op = ceb_pkg::OP_PUSH;
				right_push    = left_val[0];
				left_cnt_d    = left_cnt_q - CW'(1);
				right_cnt_d   = right_cnt_q + CW'(1);
				if (left_cnt_q == CW'(orig_left_q + CW'(1))) begin
					state_d = ceb_pkg::ST_IDLE;
				end
			end

			default: state_d = ceb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ceb_pkg::ST_IDLE;
			left_cnt_q  <= '0;
			right_cnt_q <= '0;
			orig_left_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			left_cnt_q  <= left_cnt_d;
			right_cnt_q <= right_cnt_d;
			orig_left_q <= orig_left_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the transaction while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: src/ceb_cell.sv
`default_nettype none

// One slot of each stack: slot i holds the entry i places below the top.
module ceb_cell (
	input  wire logic               clk,
	input  wire ceb_pkg::cell_ctrl_t ctrl,
	input  wire logic [7:0]         left_above,
	input  wire logic [7:0]         left_below,
	input  wire logic [7:0]         right_above,
	input  wire logic [7:0]         right_below,
	output logic      [7:0]         left_val,
	output logic      [7:0]         right_val
);

	logic [7:0] left_q;
	logic [7:0] right_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.left_op)
			ceb_pkg::OP_PUSH: left_q <= left_above;
			ceb_pkg::OP_POP:  left_q <= left_below;
			default:          left_q <= left_q;
		endcase
		unique case (ctrl.right_op)
			ceb_pkg::OP_PUSH: right_q <= right_above;
			ceb_pkg::OP_POP:  right_q <= right_below;
			default:          right_q <= right_q;
		endcase
	end

	assign left_val  = left_q;
	assign right_val = right_q;

endmodule

`default_nettype wire

// File: src/ceb_checker.sv
`default_nettype none

`include "cursor_edit_buffer_assert.svh"

module ceb_checker #(
	parameter int CAPACITY = 64
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire ceb_pkg::rsp_t rsp
);

	`CEB_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled transaction changed")

	`CEB_ASSERT_NOW(a_cursor_in_text, clk, arst_n, rsp_valid, rsp.cursor_pos <= rsp.text_length, "cursor beyond text")

	`CEB_ASSERT_NOW(a_single_result, clk, arst_n, rsp_valid && (rsp.status != ceb_pkg::STAT_DONE), rsp.last && (rsp.text_byte == 8'd0), "non-done transaction not single")

	`CEB_ASSERT_NOW(a_full_length, clk, arst_n, rsp_valid && (rsp.status == ceb_pkg::STAT_FULL), rsp.text_length == 7'(CAPACITY), "full reported below capacity")

endmodule

bind cursor_edit_buffer ceb_checker #(.CAPACITY(CAPACITY)) u_ceb_checker (.*);

`default_nettype wire

// File: verif/cursor_edit_buffer_monitor.sv
module cursor_edit_buffer_monitor #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  logic           cmd_stall,
	input  ceb_pkg::cmd_t  cmd,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  ceb_pkg::rsp_t  rsp,
	output int             mismatches,
	output int             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Text held as one ordered line; the cursor sits before line_text[caret]
	logic [7:0]     line_text[$];
	int unsigned    caret;
	ceb_pkg::rsp_t  awaited_replies[$];
	ceb_pkg::rsp_t  head;

	initial mismatches = 0;

	function automatic ceb_pkg::rsp_t make_reply(input logic [1:0] st, input logic [7:0] b,
			input logic fin);
		ceb_pkg::rsp_t r;
		r.status      = st;
		r.text_byte   = b;
		r.last        = fin;
		r.cursor_pos  = 7'(caret);
		r.text_length = 7'(line_text.size());
		return r;
	endfunction

	task automatic apply_edit(input ceb_pkg::cmd_t c);
		logic [1:0] st;
		st = ceb_pkg::STAT_DONE;
		case (c.kind)
		ceb_pkg::KIND_LEFT: begin
			if (caret == 0) st = ceb_pkg::STAT_EDGE;
			else caret--;
		end
		ceb_pkg::KIND_RIGHT: begin
			if (caret == line_text.size()) st = ceb_pkg::STAT_EDGE;
			else caret++;
		end
		ceb_pkg::KIND_BACK: begin
			if (caret == 0) begin
				st = ceb_pkg::STAT_EDGE;
			end else begin
				line_text.delete(caret - 1);
				caret--;
			end
		end
		ceb_pkg::KIND_INSERT: begin
			if (line_text.size() >= CAPACITY) begin
				st = ceb_pkg::STAT_FULL;
			end else begin
				line_text.insert(caret, c.character);
				caret++;
			end
		end
		ceb_pkg::KIND_DUMP: begin
			if (line_text.size() == 0) begin
				awaited_replies.push_back(make_reply(ceb_pkg::STAT_EMPTY, 8'h00, 1'b1));
			end else begin
				foreach (line_text[i])
					awaited_replies.push_back(make_reply(ceb_pkg::STAT_DONE, line_text[i],
						i == line_text.size() - 1));
			end
			return;
		end
		default: st = ceb_pkg::STAT_EDGE;
		endcase
		awaited_replies.push_back(make_reply(st, 8'h00, 1'b1));
	endtask

	task automatic check_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_text.delete();
			awaited_replies.delete();
			caret = 0;
			pending = 0;
		end else begin
			// Compare before predicting: a reply at this edge belongs to an older command
			if (rsp_valid && !rsp_stall) begin
				if (awaited_replies.size() == 0) begin
					$error("unexpected transaction: status %0d text_byte %0d",
						rsp.status, rsp.text_byte);
					mismatches++;
				end else begin
					head = awaited_replies.pop_front();
					check_field("status", 8'(head.status), 8'(rsp.status));
					check_field("text_byte", head.text_byte, rsp.text_byte);
					check_field("last", 8'(head.last), 8'(rsp.last));
					check_field("cursor_pos", 8'(head.cursor_pos), 8'(rsp.cursor_pos));
					check_field("text_length", 8'(head.text_length), 8'(rsp.text_length));
				end
			end
			if (cmd_valid && !cmd_stall) apply_edit(cmd);
			pending = awaited_replies.size();
		end
	end

endmodule

// File: verif/cursor_edit_buffer_test.sv
module cursor_edit_buffer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY     = 64;
	localparam int ITEM_TARGET  = 420;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 1_000_000;

	typedef enum int {
		EP_FILL,
		EP_SHRINK,
		EP_EDIT
	} episode_t;

	logic          clk;
	logic          arst_n;
	logic          cmd_valid;
	logic          cmd_stall;
	ceb_pkg::cmd_t cmd;
	logic          rsp_valid;
	logic          rsp_stall;
	ceb_pkg::rsp_t rsp;
	int            mismatches;
	int            pending;

	// Rough shadow of the line, used only to steer the stimulus
	int sent;
	int text_len;
	int cursor_at;
	bit quiet;
	bit hold_request;

	cursor_edit_buffer #(.CAPACITY(CAPACITY)) u_dut (
		.clk,
		.arst_n,
		.cmd_valid,
		.cmd_stall,
		.cmd,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	cursor_edit_buffer_monitor #(.CAPACITY(CAPACITY)) u_monitor (
		.clk,
		.arst_n,
		.cmd_valid,
		.cmd_stall,
		.cmd,
		.rsp_valid,
		.rsp_stall,
		.rsp,
		.mismatches,
		.pending
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [2:0] pick_kind();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40) return ceb_pkg::KIND_INSERT;
		if (roll < 55) return ceb_pkg::KIND_LEFT;
		if (roll < 70) return ceb_pkg::KIND_RIGHT;
		if (roll < 85) return ceb_pkg::KIND_BACK;
		if (roll < 95) return ceb_pkg::KIND_DUMP;
		return 3'($urandom_range(ceb_pkg::KIND_DUMP + 1, 7));
	endfunction

	task automatic issue(input logic [2:0] k, input logic [7:0] ch);
		cmd_valid <= 1'b1;
		cmd <= ceb_pkg::cmd_t'{kind: k, character: ch};
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		sent++;
		case (k)
		ceb_pkg::KIND_LEFT: if (cursor_at > 0) cursor_at--;
		ceb_pkg::KIND_RIGHT: if (cursor_at < text_len) cursor_at++;
		ceb_pkg::KIND_BACK: begin
			if (cursor_at > 0) begin
				cursor_at--;
				text_len--;
			end
		end
		ceb_pkg::KIND_INSERT: begin
			if (text_len < CAPACITY) begin
				cursor_at++;
				text_len++;
			end
		end
		default: ;
		endcase
		if (!quiet && $urandom_range(99) < 9) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Hold the sender until every outstanding reply has been taken
	task automatic drain_results();
		cmd_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	initial begin : receiver
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (quiet) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(99) < 9);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL cursor_edit_buffer");
		$finish;
	end

	initial begin : stimulus
		int       episode;
		int       roll;
		int       steps;
		bit       held;
		bit       paused;
		episode_t plan;
		cmd_valid <= 1'b0;
		cmd <= '0;
		arst_n <= 1'b0;
		sent = 0;
		text_len = 0;
		cursor_at = 0;
		quiet = 1'b0;
		hold_request = 1'b0;
		held = 1'b0;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Edges of an empty line, spare kinds, byte extremes, then small edits
		issue(ceb_pkg::KIND_DUMP, 8'h00);
		issue(ceb_pkg::KIND_LEFT, 8'h00);
		issue(ceb_pkg::KIND_RIGHT, 8'hFF);
		issue(ceb_pkg::KIND_BACK, 8'h00);
		for (int k = ceb_pkg::KIND_DUMP + 1; k < 8; k++) issue(3'(k), any_byte());
		issue(ceb_pkg::KIND_INSERT, 8'h00);
		issue(ceb_pkg::KIND_INSERT, 8'hFF);
		issue(ceb_pkg::KIND_INSERT, 8'h55);
		issue(ceb_pkg::KIND_INSERT, 8'hAA);
		issue(ceb_pkg::KIND_DUMP, 8'h00);
		issue(ceb_pkg::KIND_LEFT, 8'h00);
		issue(ceb_pkg::KIND_LEFT, 8'h00);
		issue(ceb_pkg::KIND_INSERT, 8'h80);
		issue(ceb_pkg::KIND_RIGHT, 8'h00);
		issue(ceb_pkg::KIND_BACK, 8'h00);
		issue(ceb_pkg::KIND_DUMP, 8'h00);
		issue(ceb_pkg::KIND_RIGHT, 8'h00);
		issue(ceb_pkg::KIND_RIGHT, 8'h00);
		issue(ceb_pkg::KIND_INSERT, 8'h01);
		issue(ceb_pkg::KIND_LEFT, 8'h00);
		issue(ceb_pkg::KIND_BACK, 8'h00);
		issue(ceb_pkg::KIND_DUMP, 8'h00);

		episode = 0;
		while (sent < ITEM_TARGET) begin
			if (!held && sent >= 150) begin
				held = 1'b1;
				hold_request = 1'b1;
			end
			if (!paused && sent >= 260) begin
				paused = 1'b1;
				drain_results();
			end
			quiet = (sent >= 300 && sent < 380);
			if (episode == 0) begin
				plan = EP_FILL;
			end else if (episode == 1) begin
				plan = EP_SHRINK;
			end else begin
				roll = $urandom_range(5);
				plan = (roll == 0) ? EP_FILL : (roll == 1) ? EP_SHRINK : EP_EDIT;
			end
			episode++;
			case (plan)
			EP_FILL: begin
				while (text_len < CAPACITY) begin
					if ($urandom_range(99) < 85) issue(ceb_pkg::KIND_INSERT, any_byte());
					else issue($urandom_range(1) ? ceb_pkg::KIND_LEFT : ceb_pkg::KIND_RIGHT,
						any_byte());
				end
				// Overflow at the end, then again with the cursor inside the line
				repeat (3) issue(ceb_pkg::KIND_INSERT, any_byte());
				repeat ($urandom_range(1, 5)) issue(ceb_pkg::KIND_LEFT, any_byte());
				repeat (2) issue(ceb_pkg::KIND_INSERT, any_byte());
				issue(ceb_pkg::KIND_DUMP, any_byte());
			end
			EP_SHRINK: begin
				steps = cursor_at + 1;
				repeat (steps) issue(ceb_pkg::KIND_BACK, any_byte());
				issue(ceb_pkg::KIND_DUMP, any_byte());
			end
			default: begin
				repeat ($urandom_range(10, 30)) issue(pick_kind(), any_byte());
				issue(ceb_pkg::KIND_DUMP, any_byte());
			end
			endcase
		end
		quiet = 1'b0;

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS cursor_edit_buffer");
		end else begin
			$display("FAIL cursor_edit_buffer");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/ceb_pkg.sv
src/ceb_cell.sv
src/cursor_edit_buffer.sv
src/ceb_checker.sv
verif/cursor_edit_buffer_monitor.sv
verif/cursor_edit_buffer_test.sv
